/* rtl/secretion_uptake_implicit_update_macros.svh */
// ----------------------------------------------------------------------------
// secretion/uptake implicit update: assertion macros
// shared concurrent assertion forms, clocked on clk, quiet in reset
// ----------------------------------------------------------------------------
`ifndef SECRETION_UPTAKE_IMPLICIT_UPDATE_MACROS_SVH
`define SECRETION_UPTAKE_IMPLICIT_UPDATE_MACROS_SVH

// same-cycle implication
`define SUIU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("suiu assertion failed");

// next-cycle implication
`define SUIU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("suiu assertion failed");

`endif

/* rtl/suiu_pkg.sv */
// ----------------------------------------------------------------------------
// suiu_pkg
// types, constants and division step functions of the implicit update
// ----------------------------------------------------------------------------
package suiu_pkg;

    localparam int KQ_W        = 48;
    localparam int KDIV_SPS    = 4;
    localparam int KDIV_STAGES = KQ_W / KDIV_SPS;
    localparam int P_STEPS     = 33;
    localparam int E_STEPS     = 32;
    localparam int LATENCY     = 1 + KDIV_STAGES + 4 + P_STEPS + 2;

    localparam logic REG_TIME_STEP      = 1'b0;
    localparam logic REG_TRACK_INTERNAL = 1'b1;

    localparam logic [31:0]        TIME_STEP_RESET = 32'd655;
    localparam logic [KQ_W-1:0]    K_MAX           = '1;
    localparam logic [65:0]        DEN_ONE         = 66'h1_0000_0000;
    localparam logic [32:0]        QE_SAT          = 33'h1_0000_0000;
    localparam logic signed [58:0] ACC_MAX         = 59'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [58:0] ACC_MIN         = -59'sh0_7FFF_FFFF_FFFF - 59'sd1;

    typedef struct packed {
        logic [31:0]        density;
        logic [31:0]        secretion_rate;
        logic [31:0]        saturation_density;
        logic [31:0]        uptake_rate;
        logic signed [31:0] export_rate;
        logic signed [47:0] internal_amount;
        logic [31:0]        cell_volume;
        logic [31:0]        voxel_volume;
        logic               agent_active;
    } req_t;

    typedef struct packed {
        logic [31:0]        rho;
        logic [31:0]        s;
        logic [31:0]        t;
        logic [31:0]        u;
        logic signed [47:0] internal;
        logic [31:0]        vv;
        logic [62:0]        emag;
        logic               e_neg;
        logic               active;
    } item_t;

    // one restoring step, returns {quotient bit, remainder}
    function automatic logic [32:0] kdiv_step(input logic [31:0] rem, input logic dbit,
                                              input logic [31:0] dv);
        logic [32:0] tr;
        logic [32:0] df;
        tr = {rem, dbit};
        df = tr - {1'b0, dv};
        if (tr >= {1'b0, dv})
            kdiv_step = {1'b1, df[31:0]};
        else
            kdiv_step = {1'b0, tr[31:0]};
    endfunction

    function automatic logic [66:0] pdiv_step(input logic [65:0] rem, input logic dbit,
                                              input logic [65:0] dv);
        logic [66:0] tr;
        logic [66:0] df;
        tr = {rem, dbit};
        df = tr - {1'b0, dv};
        if (tr >= {1'b0, dv})
            pdiv_step = {1'b1, df[65:0]};
        else
            pdiv_step = {1'b0, tr[65:0]};
    endfunction

    function automatic logic [40:0] ediv_step(input logic [39:0] rem, input logic dbit,
                                              input logic [39:0] dv);
        logic [40:0] tr;
        logic [40:0] df;
        tr = {rem, dbit};
        df = tr - {1'b0, dv};
        if (tr >= {1'b0, dv})
            ediv_step = {1'b1, df[39:0]};
        else
            ediv_step = {1'b0, tr[39:0]};
    endfunction

endpackage

/* rtl/suiu_kdiv.sv */
// ----------------------------------------------------------------------------
// suiu_kdiv
// forms dt*Vc and dt*|E|, then k = dt*Vc/Vv in Q32.16 by a pipelined divider
// ----------------------------------------------------------------------------
module suiu_kdiv (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  suiu_pkg::req_t              in_req,
    input  logic [31:0]                 time_step,
    output logic                        out_valid,
    output logic [suiu_pkg::KQ_W-1:0]   k,
    output suiu_pkg::item_t             out_item
);

    localparam int NS = suiu_pkg::KDIV_STAGES;
    localparam int QW = suiu_pkg::KQ_W;

    logic            s1_valid_reg;
    logic [63:0]     s1_prod_reg;
    suiu_pkg::item_t s1_item_reg;
    suiu_pkg::item_t s1_item_next;
    logic [63:0]     s1_prod_next;
    logic [63:0]     emag_full;
    logic [31:0]     e_raw;
    logic [31:0]     e_abs;

    always_comb
    begin
        e_raw = in_req.export_rate;
        e_abs = e_raw[31] ? (~e_raw + 32'd1) : e_raw;
        emag_full = {32'd0, time_step} * {32'd0, e_abs};
        s1_prod_next = {32'd0, time_step} * {32'd0, in_req.cell_volume};
        s1_item_next.rho      = in_req.density;
        s1_item_next.s        = in_req.secretion_rate;
        s1_item_next.t        = in_req.saturation_density;
        s1_item_next.u        = in_req.uptake_rate;
        s1_item_next.internal = in_req.internal_amount;
        s1_item_next.vv       = (in_req.voxel_volume == 32'd0) ? 32'd1 : in_req.voxel_volume;
        s1_item_next.emag     = emag_full[62:0];
        s1_item_next.e_neg    = e_raw[31];
        s1_item_next.active   = in_req.agent_active;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        s1_prod_reg <= s1_prod_next;
        s1_item_reg <= s1_item_next;
    end

    // overflow when the quotient needs more than 32 integer bits
    logic            ov0;
    logic [31:0]     rem0;
    assign ov0  = (s1_prod_reg[63:32] >= s1_item_reg.vv);
    assign rem0 = ov0 ? 32'd0 : s1_prod_reg[63:32];

    logic [NS-1:0]   vld_reg;
    logic [NS-1:0]   ov_reg;
    logic [31:0]     rem_reg  [NS];
    logic [QW-1:0]   dvd_reg  [NS];
    logic [QW-1:0]   quo_reg  [NS];
    suiu_pkg::item_t item_reg [NS];

    for (genvar j = 0; j < NS; j++)
    begin : g_stage
        logic            vld_in;
        logic            ov_in;
        logic [31:0]     rem_in;
        logic [QW-1:0]   dvd_in;
        logic [QW-1:0]   quo_in;
        suiu_pkg::item_t item_in;
        logic [31:0]     rem_next;
        logic [QW-1:0]   dvd_next;
        logic [QW-1:0]   quo_next;

        if (j == 0)
        begin : g_first
            assign vld_in  = s1_valid_reg;
            assign ov_in   = ov0;
            assign rem_in  = rem0;
            assign dvd_in  = {s1_prod_reg[31:0], 16'd0};
            assign quo_in  = '0;
            assign item_in = s1_item_reg;
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[j-1];
            assign ov_in   = ov_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign dvd_in  = dvd_reg[j-1];
            assign quo_in  = quo_reg[j-1];
            assign item_in = item_reg[j-1];
        end

        always_comb
        begin : p_steps
            logic [32:0] st;
            rem_next = rem_in;
            dvd_next = dvd_in;
            quo_next = quo_in;
            for (int b = 0; b < suiu_pkg::KDIV_SPS; b++)
            begin
                st       = suiu_pkg::kdiv_step(rem_next, dvd_next[QW-1], item_in.vv);
                rem_next = st[31:0];
                quo_next = {quo_next[QW-2:0], st[32]};
                dvd_next = {dvd_next[QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else
                vld_reg[j] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            ov_reg[j]   <= ov_in;
            rem_reg[j]  <= rem_next;
            dvd_reg[j]  <= dvd_next;
            quo_reg[j]  <= quo_next;
            item_reg[j] <= item_in;
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign k         = ov_reg[NS-1] ? suiu_pkg::K_MAX : quo_reg[NS-1];
    assign out_item  = item_reg[NS-1];

endmodule

/* rtl/suiu_pdiv.sv */
// ----------------------------------------------------------------------------
// suiu_pdiv
// scales the rates by k, forms numerator and denominator, and runs the
// density divider next to the export-term divider
// ----------------------------------------------------------------------------
module suiu_pdiv (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [suiu_pkg::KQ_W-1:0]   k,
    input  suiu_pkg::item_t             in_item,
    output logic                        out_valid,
    output logic [32:0]                 pq,
    output logic [32:0]                 qe,
    output suiu_pkg::item_t             out_item
);

    localparam int NP = suiu_pkg::P_STEPS;
    localparam int NE = suiu_pkg::E_STEPS;

    // rate products, k split into high and low parts
    logic            m1_valid_reg;
    logic [47:0]     sa_hi_reg;
    logic [63:0]     sa_lo_reg;
    logic [47:0]     ub_hi_reg;
    logic [63:0]     ub_lo_reg;
    suiu_pkg::item_t m1_item_reg;

    // a and b
    logic            m2_valid_reg;
    logic [63:0]     a_reg;
    logic [63:0]     b_reg;
    suiu_pkg::item_t m2_item_reg;
    logic [63:0]     a_next;
    logic [63:0]     b_next;

    // denominator and a*T products
    logic            m3_valid_reg;
    logic [65:0]     den3_reg;
    logic [63:0]     at_lo_reg;
    logic [63:0]     at_hi_reg;
    suiu_pkg::item_t m3_item_reg;

    // numerator
    logic            m4_valid_reg;
    logic [96:0]     num_reg;
    logic [65:0]     den4_reg;
    suiu_pkg::item_t m4_item_reg;
    logic [96:0]     num_next;

    always_comb
    begin
        a_next   = {sa_hi_reg, 16'd0} + {16'd0, sa_lo_reg[63:16]};
        b_next   = {ub_hi_reg, 16'd0} + {16'd0, ub_lo_reg[63:16]};
        num_next = {1'b0, m3_item_reg.rho, 64'd0} >> 32;
        num_next = num_next + {1'b0, at_hi_reg, 32'd0} + {33'd0, at_lo_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            m3_valid_reg <= 1'b0;
            m4_valid_reg <= 1'b0;
        end
        else
        begin
            m1_valid_reg <= in_valid;
            m2_valid_reg <= m1_valid_reg;
            m3_valid_reg <= m2_valid_reg;
            m4_valid_reg <= m3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sa_hi_reg   <= {32'd0, k[47:32]} * {16'd0, in_item.s};
        sa_lo_reg   <= {32'd0, k[31:0]} * {32'd0, in_item.s};
        ub_hi_reg   <= {32'd0, k[47:32]} * {16'd0, in_item.u};
        ub_lo_reg   <= {32'd0, k[31:0]} * {32'd0, in_item.u};
        m1_item_reg <= in_item;

        a_reg       <= a_next;
        b_reg       <= b_next;
        m2_item_reg <= m1_item_reg;

        den3_reg    <= suiu_pkg::DEN_ONE + {2'd0, a_reg} + {2'd0, b_reg};
        at_lo_reg   <= {32'd0, a_reg[31:0]} * {32'd0, m2_item_reg.t};
        at_hi_reg   <= {32'd0, a_reg[63:32]} * {32'd0, m2_item_reg.t};
        m3_item_reg <= m2_item_reg;

        num_reg     <= num_next;
        den4_reg    <= den3_reg;
        m4_item_reg <= m3_item_reg;
    end

    // divider setup
    logic        qe_ov0;
    logic [39:0] erem0;
    assign qe_ov0 = ({9'd0, m4_item_reg.emag[62:40]} >= m4_item_reg.vv);
    assign erem0  = qe_ov0 ? 40'd0 : {9'd0, m4_item_reg.emag[62:32]};

    logic [NP-1:0]   vld_reg;
    logic [NP-1:0]   qeov_reg;
    logic [65:0]     den_reg  [NP];
    logic [65:0]     prem_reg [NP];
    logic [32:0]     pdvd_reg [NP];
    logic [32:0]     pquo_reg [NP];
    logic [39:0]     erem_reg [NP];
    logic [31:0]     edvd_reg [NP];
    logic [31:0]     equo_reg [NP];
    suiu_pkg::item_t item_reg [NP];

    for (genvar j = 0; j < NP; j++)
    begin : g_stage
        logic            vld_in;
        logic            qeov_in;
        logic [65:0]     den_in;
        logic [65:0]     prem_in;
        logic [32:0]     pdvd_in;
        logic [32:0]     pquo_in;
        logic [39:0]     erem_in;
        logic [31:0]     edvd_in;
        logic [31:0]     equo_in;
        suiu_pkg::item_t item_in;
        logic [66:0]     pst;
        logic [39:0]     erem_next;
        logic [31:0]     edvd_next;
        logic [31:0]     equo_next;

        if (j == 0)
        begin : g_first
            assign vld_in  = m4_valid_reg;
            assign qeov_in = qe_ov0;
            assign den_in  = den4_reg;
            assign prem_in = {2'd0, num_reg[96:33]};
            assign pdvd_in = num_reg[32:0];
            assign pquo_in = '0;
            assign erem_in = erem0;
            assign edvd_in = m4_item_reg.emag[31:0];
            assign equo_in = '0;
            assign item_in = m4_item_reg;
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[j-1];
            assign qeov_in = qeov_reg[j-1];
            assign den_in  = den_reg[j-1];
            assign prem_in = prem_reg[j-1];
            assign pdvd_in = pdvd_reg[j-1];
            assign pquo_in = pquo_reg[j-1];
            assign erem_in = erem_reg[j-1];
            assign edvd_in = edvd_reg[j-1];
            assign equo_in = equo_reg[j-1];
            assign item_in = item_reg[j-1];
        end

        assign pst = suiu_pkg::pdiv_step(prem_in, pdvd_in[32], den_in);

        if (j < NE)
        begin : g_exp
            logic [40:0] est;
            assign est       = suiu_pkg::ediv_step(erem_in, edvd_in[31], {item_in.vv, 8'd0});
            assign erem_next = est[39:0];
            assign edvd_next = {edvd_in[30:0], 1'b0};
            assign equo_next = {equo_in[30:0], est[40]};
        end
        else
        begin : g_hold
            assign erem_next = erem_in;
            assign edvd_next = edvd_in;
            assign equo_next = equo_in;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else
                vld_reg[j] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            qeov_reg[j] <= qeov_in;
            den_reg[j]  <= den_in;
            prem_reg[j] <= pst[65:0];
            pdvd_reg[j] <= {pdvd_in[31:0], 1'b0};
            pquo_reg[j] <= {pquo_in[31:0], pst[66]};
            erem_reg[j] <= erem_next;
            edvd_reg[j] <= edvd_next;
            equo_reg[j] <= equo_next;
            item_reg[j] <= item_in;
        end
    end

    assign out_valid = vld_reg[NP-1];
    assign pq        = pquo_reg[NP-1];
    assign qe        = qeov_reg[NP-1] ? suiu_pkg::QE_SAT : {1'b0, equo_reg[NP-1]};
    assign out_item  = item_reg[NP-1];

endmodule

/* rtl/suiu_post.sv */
// ----------------------------------------------------------------------------
// suiu_post
// adds the export term, forms the internal amount change and saturates
// ----------------------------------------------------------------------------
module suiu_post (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [32:0]        pq,
    input  logic [32:0]        qe,
    input  suiu_pkg::item_t    in_item,
    input  logic               track,
    output logic               done,
    output logic [31:0]        new_density,
    output logic signed [47:0] new_internal_amount
);

    logic               p1_valid_reg;
    logic [31:0]        dens_reg;
    logic [63:0]        dprod_reg;
    logic               dneg_reg;
    suiu_pkg::item_t    p1_item_reg;

    logic [31:0]        pq32;
    logic signed [34:0] ds;
    logic [31:0]        dens_next;
    logic               dneg_next;
    logic [31:0]        dabs;

    always_comb
    begin
        pq32 = pq[32] ? 32'hFFFF_FFFF : pq[31:0];
        if (in_item.e_neg)
            ds = $signed({3'b000, pq32}) - $signed({2'b00, qe});
        else
            ds = $signed({3'b000, pq32}) + $signed({2'b00, qe});
        if (ds < 35'sd0)
            dens_next = 32'd0;
        else if (ds > $signed({3'b000, 32'hFFFF_FFFF}))
            dens_next = 32'hFFFF_FFFF;
        else
            dens_next = ds[31:0];
        dneg_next = (pq32 < in_item.rho);
        dabs      = dneg_next ? (in_item.rho - pq32) : (pq32 - in_item.rho);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else
            p1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        dens_reg    <= dens_next;
        dprod_reg   <= {32'd0, in_item.vv} * {32'd0, dabs};
        dneg_reg    <= dneg_next;
        p1_item_reg <= in_item;
    end

    logic signed [58:0] base;
    logic signed [58:0] dterm;
    logic signed [58:0] eterm;
    logic signed [58:0] acc;
    logic signed [47:0] isat;

    always_comb
    begin
        base  = $signed({{11{p1_item_reg.internal[47]}}, p1_item_reg.internal});
        dterm = $signed({3'd0, dprod_reg[63:8]});
        eterm = $signed({12'd0, p1_item_reg.emag[62:16]});
        acc   = base + (dneg_reg ? dterm : -dterm) + (p1_item_reg.e_neg ? eterm : -eterm);
        if (acc > suiu_pkg::ACC_MAX)
            isat = suiu_pkg::ACC_MAX[47:0];
        else if (acc < suiu_pkg::ACC_MIN)
            isat = suiu_pkg::ACC_MIN[47:0];
        else
            isat = acc[47:0];
    end

    logic               done_reg;
    logic [31:0]        new_density_reg;
    logic signed [47:0] new_internal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        new_density_reg  <= p1_item_reg.active ? dens_reg : p1_item_reg.rho;
        new_internal_reg <= (p1_item_reg.active && track) ? isat : p1_item_reg.internal;
    end

    assign done                = done_reg;
    assign new_density         = new_density_reg;
    assign new_internal_amount = new_internal_reg;

endmodule

/* rtl/secretion_uptake_implicit_update.sv */
// throughput: one item per cycle, busy stays low; the receiver cannot stall
// the depth is set by the k divider (4 bits a stage) and the density divider
// (1 bit a stage) running back to back
// reset: asynchronous active low, clears valid bits, dt = 655, tracking off
// ----------------------------------------------------------------------------
// secretion_uptake_implicit_update
// backward euler secretion/uptake update of one agent-substrate pair
// ----------------------------------------------------------------------------
`include "secretion_uptake_implicit_update_macros.svh"

module secretion_uptake_implicit_update (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        density,
    input  logic [31:0]        secretion_rate,
    input  logic [31:0]        saturation_density,
    input  logic [31:0]        uptake_rate,
    input  logic signed [31:0] export_rate,
    input  logic signed [47:0] internal_amount,
    input  logic [31:0]        cell_volume,
    input  logic [31:0]        voxel_volume,
    input  logic               agent_active,
    output logic               done,
    output logic [31:0]        new_density,
    output logic signed [47:0] new_internal_amount,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data
);

    logic [31:0] time_step_reg;
    logic        track_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= suiu_pkg::TIME_STEP_RESET;
            track_reg     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                suiu_pkg::REG_TIME_STEP:      time_step_reg <= cfg_data;
                suiu_pkg::REG_TRACK_INTERNAL: track_reg     <= cfg_data[0];
                default:                      track_reg     <= track_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    suiu_pkg::req_t req;
    always_comb
    begin
        req.density            = density;
        req.secretion_rate     = secretion_rate;
        req.saturation_density = saturation_density;
        req.uptake_rate        = uptake_rate;
        req.export_rate        = export_rate;
        req.internal_amount    = internal_amount;
        req.cell_volume        = cell_volume;
        req.voxel_volume       = voxel_volume;
        req.agent_active       = agent_active;
    end

    logic                      k_valid;
    logic [suiu_pkg::KQ_W-1:0] k;
    suiu_pkg::item_t           k_item;
    logic                      p_valid;
    logic [32:0]               pq;
    logic [32:0]               qe;
    suiu_pkg::item_t           p_item;

    suiu_kdiv u_kdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_req    (req),
        .time_step (time_step_reg),
        .out_valid (k_valid),
        .k         (k),
        .out_item  (k_item)
    );

    suiu_pdiv u_pdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (k_valid),
        .k         (k),
        .in_item   (k_item),
        .out_valid (p_valid),
        .pq        (pq),
        .qe        (qe),
        .out_item  (p_item)
    );

    suiu_post u_post (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (p_valid),
        .pq                  (pq),
        .qe                  (qe),
        .in_item             (p_item),
        .track               (track_reg),
        .done                (done),
        .new_density         (new_density),
        .new_internal_amount (new_internal_amount)
    );

    `SUIU_ASSERT_IMP(a_done_follows_start, done, $past(start, suiu_pkg::LATENCY))
    `SUIU_ASSERT_IMP(a_inactive_density, done, (new_density == $past(density, suiu_pkg::LATENCY)) || $past(agent_active, suiu_pkg::LATENCY))
    `SUIU_ASSERT_IMP(a_untracked_internal, done && !track_reg, new_internal_amount == $past(internal_amount, suiu_pkg::LATENCY))
    `SUIU_ASSERT_NXT(a_track_write, cfg_valid && cfg_ready && (cfg_index == suiu_pkg::REG_TRACK_INTERNAL), track_reg == $past(cfg_data[0]))

endmodule

/* verif/secretion_uptake_implicit_update_tb.sv */
// ----------------------------------------------------------------------------
// secretion_uptake_implicit_update_tb
// drives agent-substrate pairs through the implicit update, predicts density
// and internal amount for each beat and checks every done strobe in order
// ----------------------------------------------------------------------------
module secretion_uptake_implicit_update_tb;

    localparam int DRAIN_CYCLES = suiu_pkg::LATENCY + 20;
    localparam longint CYCLE_LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [31:0]        density;
    logic [31:0]        secretion_rate;
    logic [31:0]        saturation_density;
    logic [31:0]        uptake_rate;
    logic signed [31:0] export_rate;
    logic signed [47:0] internal_amount;
    logic [31:0]        cell_volume;
    logic [31:0]        voxel_volume;
    logic               agent_active;
    logic               done;
    logic [31:0]        new_density;
    logic signed [47:0] new_internal_amount;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [31:0]        cfg_data;

    typedef struct packed {
        logic [31:0]        dens;
        logic signed [47:0] amount;
    } update_t;

    update_t     pending_updates[$];
    logic [31:0] dt_shadow;
    logic        track_shadow;
    int          error_count;
    int          beats_sent;
    int          updates_checked;
    longint      cycle_count;

    secretion_uptake_implicit_update u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .density            (density),
        .secretion_rate     (secretion_rate),
        .saturation_density (saturation_density),
        .uptake_rate        (uptake_rate),
        .export_rate        (export_rate),
        .internal_amount    (internal_amount),
        .cell_volume        (cell_volume),
        .voxel_volume       (voxel_volume),
        .agent_active       (agent_active),
        .done               (done),
        .new_density        (new_density),
        .new_internal_amount(new_internal_amount),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout at %0t", $time);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic update_t predict_update(suiu_pkg::req_t rq);
        update_t     res;
        logic [63:0] vv;
        logic [63:0] prod;
        logic [63:0] kq;
        logic [63:0] kr;
        logic [63:0] k;
        logic [63:0] a;
        logic [63:0] b;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] pq;
        logic [63:0] emag;
        logic [63:0] e_abs;
        logic signed [71:0] dens;
        logic signed [71:0] diff;
        logic [71:0] dmag;
        logic signed [71:0] amt;
        res.dens = rq.density;
        res.amount = rq.internal_amount;
        if (!rq.agent_active)
            return res;
        vv = (rq.voxel_volume == 0) ? 64'd1 : {32'd0, rq.voxel_volume};
        prod = {32'd0, dt_shadow} * {32'd0, rq.cell_volume};
        kq = prod / vv;
        kr = prod % vv;
        if (kq > 64'hFFFF_FFFF)
            k = 64'hFFFF_FFFF_FFFF;
        else
            k = (kq << 16) + ((kr << 16) / vv);
        a = 64'((128'(k) * 128'(rq.secretion_rate)) >> 16);
        b = 64'((128'(k) * 128'(rq.uptake_rate)) >> 16);
        num = (128'(rq.density) << 32) + 128'(a) * 128'(rq.saturation_density);
        den = (128'd1 << 32) + 128'(a) + 128'(b);
        pq = num / den;
        if (pq > 128'hFFFF_FFFF)
            pq = 128'hFFFF_FFFF;
        e_abs = rq.export_rate < 0 ? 64'(-64'(rq.export_rate)) : 64'(rq.export_rate);
        emag = {32'd0, dt_shadow} * e_abs;
        dens = 72'(pq[63:0]);
        if (rq.export_rate < 0)
            dens = dens - 72'(emag / (vv << 8));
        else
            dens = dens + 72'(emag / (vv << 8));
        if (dens < 0)
            dens = 0;
        if (dens > 72'sh0_FFFF_FFFF)
            dens = 72'sh0_FFFF_FFFF;
        res.dens = dens[31:0];
        if (track_shadow)
        begin
            diff = 72'(pq[63:0]) - 72'(rq.density);
            dmag = 72'(vv) * 72'(diff < 0 ? -diff : diff);
            dmag = dmag >> 8;
            amt = 72'(rq.internal_amount);
            if (diff < 0)
                amt = amt + $signed(dmag);
            else
                amt = amt - $signed(dmag);
            if (rq.export_rate < 0)
                amt = amt + 72'(emag >> 16);
            else
                amt = amt - 72'(emag >> 16);
            if (amt > 72'sh7FFF_FFFF_FFFF)
                amt = 72'sh7FFF_FFFF_FFFF;
            if (amt < -72'sh8000_0000_0000)
                amt = -72'sh8000_0000_0000;
            res.amount = amt[47:0];
        end
        return res;
    endfunction

    // compare each done beat with the oldest expectation
    initial
    begin
        update_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && done)
            begin
                if (pending_updates.size() == 0)
                begin
                    $display("%0t: unexpected result dens=%h amount=%h", $time,
                             new_density, new_internal_amount);
                    error_count++;
                end
                else
                begin
                    want = pending_updates.pop_front();
                    updates_checked++;
                    if (new_density !== want.dens)
                    begin
                        $display("%0t: new_density expected %h actual %h", $time,
                                 want.dens, new_density);
                        error_count++;
                    end
                    if (new_internal_amount !== want.amount)
                    begin
                        $display("%0t: new_internal_amount expected %h actual %h", $time,
                                 want.amount, new_internal_amount);
                        error_count++;
                    end
                end
            end
        end
    end

    function automatic int gap_len();
        int n;
        n = $urandom_range(0, 99);
        if (n < 50)
            n = 0;
        else if (n < 92)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(5, 40);
        return n;
    endfunction

    // start stays high after the beat so the next one can follow directly
    task automatic send_item(suiu_pkg::req_t rq, bit gaps);
        int n;
        n = gaps ? gap_len() : 0;
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
        start              <= 1'b1;
        density            <= rq.density;
        secretion_rate     <= rq.secretion_rate;
        saturation_density <= rq.saturation_density;
        uptake_rate        <= rq.uptake_rate;
        export_rate        <= rq.export_rate;
        internal_amount    <= rq.internal_amount;
        cell_volume        <= rq.cell_volume;
        voxel_volume       <= rq.voxel_volume;
        agent_active       <= rq.agent_active;
        do
            @(posedge clk);
        while (busy);
        pending_updates.insert(pending_updates.size(), predict_update(rq));
        beats_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_updates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == suiu_pkg::REG_TIME_STEP)
            dt_shadow = val;
        else
            track_shadow = val[0];
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        unique case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 255);
            3: return $urandom_range(0, 32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic suiu_pkg::req_t rand_req();
        suiu_pkg::req_t rq;
        rq.density            = rand_word();
        rq.secretion_rate     = rand_word();
        rq.saturation_density = rand_word();
        rq.uptake_rate        = rand_word();
        rq.export_rate        = rand_word();
        rq.internal_amount    = 48'({$urandom, $urandom} >> ($urandom_range(0, 1) ? 16 : 40));
        if ($urandom_range(0, 1))
            rq.internal_amount = -rq.internal_amount;
        if ($urandom_range(0, 15) == 0)
            rq.internal_amount = $urandom_range(0, 1) ? 48'sh7FFF_FFFF_FFFF
                                                      : 48'sh8000_0000_0000;
        rq.cell_volume        = rand_word();
        rq.voxel_volume       = rand_word();
        rq.agent_active       = $urandom_range(0, 9) != 0;
        return rq;
    endfunction

    task automatic test_directed();
        suiu_pkg::req_t rq;
        rq = '{density: 32'h0001_0000, secretion_rate: 32'h0000_8000,
               saturation_density: 32'h0002_0000, uptake_rate: 32'h0000_4000,
               export_rate: 32'sh0000_1000, internal_amount: 48'sh0000_0010_0000,
               cell_volume: 32'h0000_1000, voxel_volume: 32'h0000_8000,
               agent_active: 1'b1};
        send_item(rq, 0);
        rq.agent_active = 1'b0;
        send_item(rq, 0);
        rq.agent_active = 1'b1;
        rq.voxel_volume = 32'd0;
        send_item(rq, 0);
        rq = '{density: '1, secretion_rate: '1, saturation_density: '1, uptake_rate: '1,
               export_rate: 32'sh7FFF_FFFF, internal_amount: 48'sh7FFF_FFFF_FFFF,
               cell_volume: '1, voxel_volume: 32'd1, agent_active: 1'b1};
        send_item(rq, 0);
        rq.export_rate = 32'sh8000_0000;
        rq.internal_amount = 48'sh8000_0000_0000;
        send_item(rq, 0);
        rq.density = 32'd0;
        rq.uptake_rate = 32'd0;
        send_item(rq, 0);
        rq = '0;
        rq.voxel_volume = '1;
        rq.agent_active = 1'b1;
        send_item(rq, 0);
        wait_drained();
        write_reg(suiu_pkg::REG_TRACK_INTERNAL, 32'd1);
        write_reg(suiu_pkg::REG_TIME_STEP, 32'd0);
        rq.density = 32'h1234_5678;
        rq.export_rate = -32'sd5000;
        send_item(rq, 0);
        wait_drained();
        write_reg(suiu_pkg::REG_TIME_STEP, 32'hFFFF_FFFF);
        rq = '{density: 32'h0000_0100, secretion_rate: '1, saturation_density: '1,
               uptake_rate: 32'd0, export_rate: 32'sh8000_0000,
               internal_amount: 48'sh8000_0000_0000, cell_volume: '1,
               voxel_volume: 32'd1, agent_active: 1'b1};
        send_item(rq, 0);
        rq.export_rate = 32'sh7FFF_FFFF;
        rq.internal_amount = 48'sh7FFF_FFFF_FFFF;
        rq.secretion_rate = 32'd0;
        rq.uptake_rate = '1;
        rq.density = '1;
        send_item(rq, 0);
        rq.voxel_volume = '1;
        send_item(rq, 0);
        wait_drained();
    endtask

    task automatic test_random(int count, logic [31:0] dt, logic trk);
        write_reg(suiu_pkg::REG_TIME_STEP, dt);
        write_reg(suiu_pkg::REG_TRACK_INTERNAL, {31'd0, trk});
        for (int i = 0; i < count; i++)
        begin
            if (i % 60 < 15)
                send_item(rand_req(), 0);
            else
                send_item(rand_req(), 1);
            if (i == count / 2)
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        error_count     = 0;
        beats_sent      = 0;
        updates_checked = 0;
        dt_shadow       = suiu_pkg::TIME_STEP_RESET;
        track_shadow    = 1'b0;
        rst_n              = 1'b0;
        start              = 1'b0;
        density            = '0;
        secretion_rate     = '0;
        saturation_density = '0;
        uptake_rate        = '0;
        export_rate        = '0;
        internal_amount    = '0;
        cell_volume        = '0;
        voxel_volume       = '0;
        agent_active       = 1'b0;
        cfg_valid          = 1'b0;
        cfg_index          = suiu_pkg::REG_TIME_STEP;
        cfg_data           = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(160, suiu_pkg::TIME_STEP_RESET, 1'b1);
        test_random(160, 32'd1, 1'b0);
        test_random(160, 32'hFFFF_FFFF, 1'b1);
        test_random(160, 32'h0001_0000, 1'b1);
        test_random(160, $urandom, 1'b0);
        test_random(150, $urandom_range(1, 32'h0010_0000), 1'b1);

        $display("%0d beats sent, %0d results checked, dt from 0 to max, tracking on and off",
                 beats_sent, updates_checked);
        if (error_count == 0 && pending_updates.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
